>>> rtl/core/pcf_pkg.sv
// ----------------------------------------------------------------------------
// pcf_pkg
// Shared types, codes and helpers of the path curve flattener.
// ----------------------------------------------------------------------------
package pcf_pkg;

	localparam logic [2:0] OP_CUBIC        = 3'd0;
	localparam logic [2:0] OP_SMOOTH_CUBIC = 3'd1;
	localparam logic [2:0] OP_QUAD         = 3'd2;
	localparam logic [2:0] OP_SMOOTH_QUAD  = 3'd3;

	localparam logic [1:0] FAM_NONE  = 2'd0;
	localparam logic [1:0] FAM_CUBIC = 2'd1;
	localparam logic [1:0] FAM_QUAD  = 2'd2;

	localparam logic REG_SEGMENT_COUNT = 1'b0;
	localparam logic [6:0] SEG_RESET   = 7'd16;

	// quotient bits produced by the divider
	localparam int DIV_QW = 34;

	typedef struct packed {
		logic busy;
		logic done;
	} div_sts_t;

	typedef struct packed {
		logic        push;
		logic        flush;
		logic [31:0] x;
		logic [31:0] y;
	} out_cmd_t;

	typedef struct packed {
		logic room;
	} out_sts_t;

	function automatic logic signed [31:0] sat32(input logic signed [33:0] v);
		logic signed [31:0] r;
		if (v > 34'sh0_7FFF_FFFF) begin
			r = 32'sh7FFF_FFFF;
		end else if (v < -34'sh0_8000_0000) begin
			r = 32'sh8000_0000;
		end else begin
			r = v[31:0];
		end
		return r;
	endfunction

endpackage

>>> rtl/core/pcf_div.sv
// ----------------------------------------------------------------------------
// pcf_div
// Radix-2 restoring divider: signed numerator, positive denominator,
// floor quotient. One quotient bit per cycle.
// ----------------------------------------------------------------------------
module pcf_div import pcf_pkg::*; #(
	parameter int NUM_W = 38,
	parameter int DEN_W = 4
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	input  logic signed [NUM_W-1:0] num,
	input  logic [DEN_W-1:0]        den,
	output logic signed [DIV_QW-1:0] quo,
	output div_sts_t                sts
);

	localparam int CW = $clog2(DIV_QW + 1);

	logic [NUM_W-1:0]  mag;
	logic [DEN_W-1:0]  rem_q;
	logic [DEN_W-1:0]  den_q;
	logic [DIV_QW-1:0] lo_q;
	logic [CW-1:0]     cnt_q;
	logic              neg_q;
	logic              busy_q;
	logic              done_q;
	logic [DEN_W:0]    r2;
	logic [DEN_W:0]    diff;
	logic              ge;

	assign mag  = num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
	assign r2   = {rem_q, lo_q[DIV_QW-1]};
	assign diff = r2 - {1'b0, den_q};
	assign ge   = r2 >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			if (start) begin
				busy_q <= 1'b1;
				done_q <= 1'b0;
				cnt_q  <= CW'(DIV_QW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					done_q <= 1'b0;
				end
			end else begin
				done_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			neg_q <= num[NUM_W-1];
			den_q <= den;
			rem_q <= DEN_W'(mag[NUM_W-1:DIV_QW]);
			lo_q  <= mag[DIV_QW-1:0];
		end else if (busy_q) begin
			rem_q <= ge ? diff[DEN_W-1:0] : r2[DEN_W-1:0];
			lo_q  <= {lo_q[DIV_QW-2:0], ge};
		end
	end

	// floor for negative numerators: -q, or -q-1 when a remainder is left
	always_comb begin
		if (!neg_q) begin
			quo = lo_q;
		end else if (rem_q != '0) begin
			quo = ~lo_q;
		end else begin
			quo = -lo_q;
		end
	end

	assign sts.busy = busy_q;
	assign sts.done = done_q;

endmodule

>>> rtl/core/pcf_out.sv
// ----------------------------------------------------------------------------
// pcf_out
// Result staging: holds one pending point so the last flag can be set when
// the curve ends, plus the output register.
// ----------------------------------------------------------------------------
module pcf_out import pcf_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  out_cmd_t    cmd,
	output out_sts_t    sts,
	output logic        point_valid,
	input  logic        point_ready,
	output logic [31:0] point_x,
	output logic [31:0] point_y,
	output logic        last
);

	logic        pv_q;
	logic [31:0] px_q;
	logic [31:0] py_q;
	logic        ov_q;
	logic [31:0] ox_q;
	logic [31:0] oy_q;
	logic        ol_q;
	logic        room;
	logic        load;

	assign room = !ov_q || point_ready;
	assign load = room && pv_q && (cmd.push || cmd.flush);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pv_q <= 1'b0;
			ov_q <= 1'b0;
		end else begin
			if (load) begin
				ov_q <= 1'b1;
			end else if (point_ready) begin
				ov_q <= 1'b0;
			end
			if (cmd.push && room) begin
				pv_q <= 1'b1;
			end else if (cmd.flush && room) begin
				pv_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			ox_q <= px_q;
			oy_q <= py_q;
			ol_q <= cmd.flush;
		end
		if (cmd.push && room) begin
			px_q <= cmd.x;
			py_q <= cmd.y;
		end
	end

	assign sts.room    = room;
	assign point_valid = ov_q;
	assign point_x     = ox_q;
	assign point_y     = oy_q;
	assign last        = ol_q;

endmodule

>>> rtl/core/path_curve_flattener.sv
// ----------------------------------------------------------------------------
// path_curve_flattener
// Flattens cubic and quadratic curve commands into polyline points.
// ----------------------------------------------------------------------------
// One shared multiplier and one radix-2 divider run under a sequencer; a
// command is taken only when the block is idle. A quadratic first spends
// 4 divides raising its controls through the divider. Every segment then
// takes 6 multiplies for the Bernstein weights and, per axis,
// 4 multiply-accumulates plus a divide by N^3. A curve's run is stretched
// by any cycles in which a point waits on the output; an "other" command
// is taken without leaving the idle state. The last point of a curve
// carries last, and a point equal to its predecessor is dropped.
// ----------------------------------------------------------------------------
module path_curve_flattener import pcf_pkg::*; #(
	parameter int MAX_SEGMENTS = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        cmd_valid,
	output logic        cmd_ready,
	input  logic [2:0]  op,
	input  logic        relative,
	input  logic signed [31:0] start_x,
	input  logic signed [31:0] start_y,
	input  logic signed [31:0] ctrl_a_x,
	input  logic signed [31:0] ctrl_a_y,
	input  logic signed [31:0] ctrl_b_x,
	input  logic signed [31:0] ctrl_b_y,
	input  logic signed [31:0] end_x,
	input  logic signed [31:0] end_y,
	output logic        point_valid,
	input  logic        point_ready,
	output logic signed [31:0] point_x,
	output logic signed [31:0] point_y,
	output logic        last
);

	localparam int NB    = $clog2(MAX_SEGMENTS + 1);
	localparam int WW    = 3 * NB + 2;
	localparam int PW    = 33 + WW + 1;
	localparam int ACC_W = 3 * NB + 33;
	localparam int DNW   = 3 * NB + 35;
	localparam int DEN_W = 3 * NB + 1;

	typedef enum logic [8:0] {
		ST_IDLE     = 9'b000000001,
		ST_RAISE_GO = 9'b000000010,
		ST_RAISE_WT = 9'b000000100,
		ST_CUBE     = 9'b000001000,
		ST_WGT      = 9'b000010000,
		ST_ACC      = 9'b000100000,
		ST_DIV_WT   = 9'b001000000,
		ST_EMIT     = 9'b010000000,
		ST_FLUSH    = 9'b100000000
	} st_t;

	st_t st_q;

	logic [6:0]  seg_q;
	logic [1:0]  fam_q;
	logic signed [31:0] cc_x_q, cc_y_q, qc_x_q, qc_y_q;
	logic signed [31:0] s_x_q, s_y_q, c1_x_q, c1_y_q, c2_x_q, c2_y_q, e_x_q, e_y_q;
	logic signed [31:0] q_x_q, q_y_q;
	logic signed [31:0] xr_q, yr_q, px_q, py_q;
	logic [NB-1:0]  n_q, i_q;
	logic [3*NB-1:0] n3_q;
	logic [WW-1:0]  t1_q, t3_q, w0_q, w1_q, w2_q, w3_q;
	logic [2:0]     k_q;
	logic [1:0]     r_q;
	logic           sel_q;
	logic signed [PW-1:0]    prod_q;
	logic signed [ACC_W-1:0] acc_q;

	// ---------------- configuration port
	logic cfg_wr;
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_SEGMENT_COUNT);
	assign prdata = (paddr[2] == REG_SEGMENT_COUNT) ? 32'(seg_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seg_q <= SEG_RESET;
		end else if (cfg_wr) begin
			seg_q <= pwdata[6:0];
		end
	end

	// ---------------- command decode
	logic signed [31:0] ra_x, ra_y, rb_x, rb_y, re_x, re_y;
	logic signed [31:0] refl_cx, refl_cy, refl_qx, refl_qy;
	logic [NB-1:0]      n_clamp;
	logic               accept;
	logic               is_curve;
	logic               is_cubic;

	assign ra_x = relative ? sat32(34'(ctrl_a_x) + 34'(start_x)) : ctrl_a_x;
	assign ra_y = relative ? sat32(34'(ctrl_a_y) + 34'(start_y)) : ctrl_a_y;
	assign rb_x = relative ? sat32(34'(ctrl_b_x) + 34'(start_x)) : ctrl_b_x;
	assign rb_y = relative ? sat32(34'(ctrl_b_y) + 34'(start_y)) : ctrl_b_y;
	assign re_x = relative ? sat32(34'(end_x) + 34'(start_x)) : end_x;
	assign re_y = relative ? sat32(34'(end_y) + 34'(start_y)) : end_y;

	assign refl_cx = sat32((34'(start_x) <<< 1) - 34'(cc_x_q));
	assign refl_cy = sat32((34'(start_y) <<< 1) - 34'(cc_y_q));
	assign refl_qx = sat32((34'(start_x) <<< 1) - 34'(qc_x_q));
	assign refl_qy = sat32((34'(start_y) <<< 1) - 34'(qc_y_q));

	assign n_clamp = (seg_q == '0) ? NB'(1) :
		(32'(seg_q) > MAX_SEGMENTS) ? NB'(MAX_SEGMENTS) : NB'(seg_q);

	assign cmd_ready = (st_q == ST_IDLE);
	assign accept    = cmd_valid && cmd_ready;
	assign is_cubic  = (op == OP_CUBIC) || (op == OP_SMOOTH_CUBIC);
	assign is_curve  = is_cubic || (op == OP_QUAD) || (op == OP_SMOOTH_QUAD);

	// ---------------- shared multiplier
	logic [NB-1:0]        m;
	logic signed [32:0]   mul_a;
	logic signed [WW:0]   mul_b;
	logic [32:0]          prod_lo;

	assign m       = n_q - i_q;
	assign prod_lo = 33'(prod_q[WW-1:0]);

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (st_q)
			ST_CUBE: begin
				mul_a = (k_q == 3'd0) ? 33'(n_q) : prod_lo;
				mul_b = (WW+1)'(n_q);
			end
			ST_WGT: begin
				case (k_q)
					3'd0: begin mul_a = 33'(m);    mul_b = (WW+1)'(m); end
					3'd1: begin mul_a = prod_lo;   mul_b = (WW+1)'(m); end
					3'd2: begin mul_a = 33'(t1_q); mul_b = (WW+1)'(i_q); end
					3'd3: begin mul_a = 33'(i_q);  mul_b = (WW+1)'(i_q); end
					3'd4: begin mul_a = prod_lo;   mul_b = (WW+1)'(i_q); end
					3'd5: begin mul_a = 33'(t3_q); mul_b = (WW+1)'(m); end
					default: begin mul_a = '0; mul_b = '0; end
				endcase
			end
			ST_ACC: begin
				case (k_q)
					3'd0: begin
						mul_a = 33'(sel_q ? s_y_q : s_x_q);
						mul_b = {1'b0, w0_q};
					end
					3'd1: begin
						mul_a = 33'(sel_q ? c1_y_q : c1_x_q);
						mul_b = {1'b0, w1_q};
					end
					3'd2: begin
						mul_a = 33'(sel_q ? c2_y_q : c2_x_q);
						mul_b = {1'b0, w2_q};
					end
					3'd3: begin
						mul_a = 33'(sel_q ? e_y_q : e_x_q);
						mul_b = {1'b0, w3_q};
					end
					default: begin mul_a = '0; mul_b = '0; end
				endcase
			end
			default: begin mul_a = '0; mul_b = '0; end
		endcase
	end

	always_ff @(posedge clk) begin
		prod_q <= mul_a * mul_b;
	end

	// ---------------- shared divider
	logic signed [31:0]    rb_base, rq_val;
	logic signed [33:0]    rdiff;
	logic signed [DNW-1:0] raise_num, acc_num, div_num;
	logic [DEN_W-1:0]      div_den;
	logic                  div_start;
	logic signed [DIV_QW-1:0] div_quo;
	div_sts_t              div_sts;
	logic signed [33:0]    raised;

	always_comb begin
		case (r_q)
			2'd0: begin rb_base = s_x_q; rq_val = q_x_q; end
			2'd1: begin rb_base = s_y_q; rq_val = q_y_q; end
			2'd2: begin rb_base = e_x_q; rq_val = q_x_q; end
			2'd3: begin rb_base = e_y_q; rq_val = q_y_q; end
			default: begin rb_base = s_x_q; rq_val = q_x_q; end
		endcase
	end

	// round(2(q-base)/3) as floor((4(q-base)+3)/6)
	assign rdiff     = 34'(rq_val) - 34'(rb_base);
	assign raise_num = (DNW'(rdiff) <<< 2) + DNW'(3);
	assign acc_num   = (DNW'(acc_q) <<< 1) + $signed(DNW'(n3_q));
	assign div_start = (st_q == ST_RAISE_GO) || ((st_q == ST_ACC) && (k_q == 3'd5));
	assign div_num   = (st_q == ST_RAISE_GO) ? raise_num : acc_num;
	assign div_den   = (st_q == ST_RAISE_GO) ? DEN_W'(6) : DEN_W'({n3_q, 1'b0});
	assign raised    = 34'(rb_base) + 34'(div_quo);

	pcf_div #(
		.NUM_W (DNW),
		.DEN_W (DEN_W)
	) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num),
		.den    (div_den),
		.quo    (div_quo),
		.sts    (div_sts)
	);

	// ---------------- result staging
	out_cmd_t ocmd;
	out_sts_t osts;
	logic     same;

	assign same = (xr_q == px_q) && (yr_q == py_q);

	always_comb begin
		ocmd.push  = (st_q == ST_EMIT) && !same && osts.room;
		ocmd.flush = (st_q == ST_FLUSH) && osts.room;
		ocmd.x     = xr_q;
		ocmd.y     = yr_q;
	end

	pcf_out u_out (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (ocmd),
		.sts         (osts),
		.point_valid (point_valid),
		.point_ready (point_ready),
		.point_x     (point_x),
		.point_y     (point_y),
		.last        (last)
	);

	// ---------------- sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q  <= ST_IDLE;
			fam_q <= FAM_NONE;
			k_q   <= '0;
			r_q   <= '0;
			sel_q <= 1'b0;
			i_q   <= '0;
			n_q   <= '0;
		end else begin
			case (st_q)
				ST_IDLE: begin
					if (accept) begin
						n_q   <= n_clamp;
						i_q   <= NB'(1);
						k_q   <= '0;
						r_q   <= '0;
						if (!is_curve) begin
							fam_q <= FAM_NONE;
						end else if (is_cubic) begin
							fam_q <= FAM_CUBIC;
							st_q  <= ST_CUBE;
						end else begin
							fam_q <= FAM_QUAD;
							st_q  <= ST_RAISE_GO;
						end
					end
				end
				ST_RAISE_GO: begin
					st_q <= ST_RAISE_WT;
				end
				ST_RAISE_WT: begin
					if (div_sts.done) begin
						r_q <= r_q + 1'b1;
						st_q <= (r_q == 2'd3) ? ST_CUBE : ST_RAISE_GO;
					end
				end
				ST_CUBE: begin
					if (k_q == 3'd2) begin
						k_q  <= '0;
						st_q <= ST_WGT;
					end else begin
						k_q <= k_q + 1'b1;
					end
				end
				ST_WGT: begin
					if (k_q == 3'd6) begin
						k_q   <= '0;
						sel_q <= 1'b0;
						st_q  <= ST_ACC;
					end else begin
						k_q <= k_q + 1'b1;
					end
				end
				ST_ACC: begin
					k_q <= k_q + 1'b1;
					if (k_q == 3'd5) begin
						st_q <= ST_DIV_WT;
					end
				end
				ST_DIV_WT: begin
					if (div_sts.done) begin
						k_q <= '0;
						if (!sel_q) begin
							sel_q <= 1'b1;
							st_q  <= ST_ACC;
						end else begin
							st_q <= ST_EMIT;
						end
					end
				end
				ST_EMIT: begin
					if (same || osts.room) begin
						if (i_q == n_q) begin
							st_q <= ST_FLUSH;
						end else begin
							i_q  <= i_q + 1'b1;
							st_q <= ST_WGT;
						end
					end
				end
				ST_FLUSH: begin
					if (osts.room) begin
						st_q <= ST_IDLE;
					end
				end
				default: begin
					st_q <= ST_IDLE;
				end
			endcase
		end
	end

	// control point history: reset to zero, updated by every curve command
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cc_x_q <= '0;
			cc_y_q <= '0;
			qc_x_q <= '0;
			qc_y_q <= '0;
		end else if (accept && is_cubic) begin
			cc_x_q <= rb_x;
			cc_y_q <= rb_y;
		end else if (accept && is_curve) begin
			qc_x_q <= (op == OP_QUAD) ? ra_x : ((fam_q == FAM_QUAD) ? refl_qx : start_x);
			qc_y_q <= (op == OP_QUAD) ? ra_y : ((fam_q == FAM_QUAD) ? refl_qy : start_y);
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (accept) begin
			s_x_q <= start_x;
			s_y_q <= start_y;
			px_q  <= start_x;
			py_q  <= start_y;
			e_x_q <= re_x;
			e_y_q <= re_y;
			c2_x_q <= rb_x;
			c2_y_q <= rb_y;
			if (op == OP_CUBIC) begin
				c1_x_q <= ra_x;
				c1_y_q <= ra_y;
			end else if (fam_q == FAM_CUBIC) begin
				c1_x_q <= refl_cx;
				c1_y_q <= refl_cy;
			end else begin
				c1_x_q <= start_x;
				c1_y_q <= start_y;
			end
			q_x_q <= (op == OP_QUAD) ? ra_x : ((fam_q == FAM_QUAD) ? refl_qx : start_x);
			q_y_q <= (op == OP_QUAD) ? ra_y : ((fam_q == FAM_QUAD) ? refl_qy : start_y);
		end
		if (st_q == ST_RAISE_WT && div_sts.done) begin
			case (r_q)
				2'd0: c1_x_q <= raised[31:0];
				2'd1: c1_y_q <= raised[31:0];
				2'd2: c2_x_q <= raised[31:0];
				2'd3: c2_y_q <= raised[31:0];
				default: c1_x_q <= raised[31:0];
			endcase
		end
		if (st_q == ST_CUBE && k_q == 3'd2) begin
			n3_q <= prod_q[3*NB-1:0];
		end
		if (st_q == ST_WGT) begin
			case (k_q)
				3'd1: t1_q <= prod_q[WW-1:0];
				3'd2: w0_q <= prod_q[WW-1:0];
				3'd3: w1_q <= WW'({prod_q[WW-1:0], 1'b0} + {1'b0, prod_q[WW-1:0]});
				3'd4: t3_q <= prod_q[WW-1:0];
				3'd5: w3_q <= prod_q[WW-1:0];
				3'd6: w2_q <= WW'({prod_q[WW-1:0], 1'b0} + {1'b0, prod_q[WW-1:0]});
				default: t1_q <= t1_q;
			endcase
		end
		if (st_q == ST_ACC) begin
			if (k_q == 3'd1) begin
				acc_q <= ACC_W'(prod_q);
			end else if (k_q == 3'd2 || k_q == 3'd3 || k_q == 3'd4) begin
				acc_q <= acc_q + ACC_W'(prod_q);
			end
		end
		if (st_q == ST_DIV_WT && div_sts.done) begin
			if (!sel_q) begin
				xr_q <= div_quo[31:0];
			end else begin
				yr_q <= div_quo[31:0];
			end
		end
		if (ocmd.push) begin
			px_q <= xr_q;
			py_q <= yr_q;
		end
	end

endmodule

>>> rtl/core/pcf_chk.sv
// ----------------------------------------------------------------------------
// pcf_chk
// Port-level checks of the path curve flattener, bound to the top level.
// ----------------------------------------------------------------------------
module pcf_chk import pcf_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	input logic        cmd_valid,
	input logic        cmd_ready,
	input logic [2:0]  op,
	input logic        point_valid,
	input logic        point_ready,
	input logic [31:0] point_x,
	input logic [31:0] point_y,
	input logic        last
);

	// a curve transfer keeps the block busy in the next cycle
	a_curve_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd_valid && cmd_ready && (op == OP_CUBIC || op == OP_SMOOTH_CUBIC ||
		op == OP_QUAD || op == OP_SMOOTH_QUAD)) |=> !cmd_ready)
		else $error("ready after curve command");

	// any other command leaves the block ready again in the next cycle
	a_other_quick: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd_valid && cmd_ready && !(op == OP_CUBIC || op == OP_SMOOTH_CUBIC ||
		op == OP_QUAD || op == OP_SMOOTH_QUAD)) |=> cmd_ready)
		else $error("block busy after non-curve command");

	// no point is valid in the cycle in which reset is seen released
	a_reset_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(arst_n) |-> !point_valid)
		else $error("point valid right after reset");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(point_valid && !point_ready) |=>
		(point_valid && $stable(point_x) && $stable(point_y) && $stable(last)))
		else $error("stalled point changed");

endmodule

bind path_curve_flattener pcf_chk u_pcf_chk (
	.clk         (clk),
	.arst_n      (arst_n),
	.cmd_valid   (cmd_valid),
	.cmd_ready   (cmd_ready),
	.op          (op),
	.point_valid (point_valid),
	.point_ready (point_ready),
	.point_x     (point_x),
	.point_y     (point_y),
	.last        (last)
);

>>> bench/pcf_checker.sv
// ----------------------------------------------------------------------------
// pcf_checker
// Watches the configuration port and both streams of the curve flattener,
// predicts every flattened point and compares it with what the block emits.
// ----------------------------------------------------------------------------
module pcf_checker import pcf_pkg::*; #(
	parameter int MAX_SEGMENTS = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	input  logic        pready,
	input  logic        cmd_valid,
	input  logic        cmd_ready,
	input  logic [2:0]  op,
	input  logic        relative,
	input  logic [31:0] start_x,
	input  logic [31:0] start_y,
	input  logic [31:0] ctrl_a_x,
	input  logic [31:0] ctrl_a_y,
	input  logic [31:0] ctrl_b_x,
	input  logic [31:0] ctrl_b_y,
	input  logic [31:0] end_x,
	input  logic [31:0] end_y,
	input  logic        point_valid,
	input  logic        point_ready,
	input  logic [31:0] point_x,
	input  logic [31:0] point_y,
	input  logic        last,
	output int          errors,
	output int          pending
);

	typedef struct {
		logic [31:0] x;
		logic [31:0] y;
		logic        last;
	} poly_point_t;

	poly_point_t pts_q[$];
	logic [6:0]  seg_count;
	longint      cubic_cx, cubic_cy, quad_cx, quad_cy;
	logic [1:0]  family;
	int          err_cnt;

	function automatic longint clamp_q16(longint v);
		if (v > 64'sd2147483647) return 64'sd2147483647;
		if (v < -64'sd2147483648) return -64'sd2147483648;
		return v;
	endfunction

	// round to nearest, ties toward plus infinity
	function automatic longint div_nearest(longint num, longint den);
		longint n, d, q;
		n = 2 * num + den;
		d = 2 * den;
		q = n / d;
		if ((n % d) != 0 && n < 0) q--;
		return q;
	endfunction

	function automatic longint raise_quad(longint base, longint q);
		return base + div_nearest(2 * (q - base), 3);
	endfunction

	task automatic flatten_curve();
		longint sx, sy, ax, ay, bx, by, ex, ey;
		longint c1x, c1y, c2x, c2y, qx, qy;
		longint n, n3, m, w0, w1, w2, w3, x, y, px, py;
		int     emitted;
		sx = longint'($signed(start_x));  sy = longint'($signed(start_y));
		ax = longint'($signed(ctrl_a_x)); ay = longint'($signed(ctrl_a_y));
		bx = longint'($signed(ctrl_b_x)); by = longint'($signed(ctrl_b_y));
		ex = longint'($signed(end_x));    ey = longint'($signed(end_y));
		emitted = 0;
		if (op > OP_SMOOTH_QUAD) begin
			family = FAM_NONE;
			return;
		end
		if (relative) begin
			ax = clamp_q16(ax + sx); ay = clamp_q16(ay + sy);
			bx = clamp_q16(bx + sx); by = clamp_q16(by + sy);
			ex = clamp_q16(ex + sx); ey = clamp_q16(ey + sy);
		end
		if (op == OP_CUBIC || op == OP_SMOOTH_CUBIC) begin
			if (op == OP_CUBIC) begin
				c1x = ax; c1y = ay;
			end else if (family == FAM_CUBIC) begin
				c1x = clamp_q16(2 * sx - cubic_cx);
				c1y = clamp_q16(2 * sy - cubic_cy);
			end else begin
				c1x = sx; c1y = sy;
			end
			c2x = bx; c2y = by;
			cubic_cx = c2x; cubic_cy = c2y;
			family = FAM_CUBIC;
		end else begin
			if (op == OP_QUAD) begin
				qx = ax; qy = ay;
			end else if (family == FAM_QUAD) begin
				qx = clamp_q16(2 * sx - quad_cx);
				qy = clamp_q16(2 * sy - quad_cy);
			end else begin
				qx = sx; qy = sy;
			end
			c1x = raise_quad(sx, qx); c1y = raise_quad(sy, qy);
			c2x = raise_quad(ex, qx); c2y = raise_quad(ey, qy);
			quad_cx = qx; quad_cy = qy;
			family = FAM_QUAD;
		end
		n = seg_count;
		if (n < 1) n = 1;
		if (n > MAX_SEGMENTS) n = MAX_SEGMENTS;
		n3 = n * n * n;
		px = sx; py = sy;
		for (longint i = 1; i <= n; i++) begin
			m  = n - i;
			w0 = m * m * m;
			w1 = 3 * m * m * i;
			w2 = 3 * m * i * i;
			w3 = i * i * i;
			x = div_nearest(w0 * sx + w1 * c1x + w2 * c2x + w3 * ex, n3);
			y = div_nearest(w0 * sy + w1 * c1y + w2 * c2y + w3 * ey, n3);
			if (x == px && y == py) continue;
			pts_q.push_back('{x: x[31:0], y: y[31:0], last: 1'b0});
			emitted++;
			px = x; py = y;
		end
		if (emitted > 0) pts_q[pts_q.size() - 1].last = 1'b1;
	endtask

	always @(posedge clk or negedge arst_n) begin
		poly_point_t want;
		if (!arst_n) begin
			seg_count = SEG_RESET;
			cubic_cx = 0; cubic_cy = 0;
			quad_cx = 0;  quad_cy = 0;
			family = FAM_NONE;
			err_cnt = 0;
			pts_q.delete();
			errors <= 0;
			pending <= 0;
		end else begin
			if (psel && penable && pwrite && pready && paddr[2] == REG_SEGMENT_COUNT)
				seg_count = pwdata[6:0];
			// retire before predicting: a new command never overlaps its own points
			if (point_valid && point_ready) begin
				if (pts_q.size() == 0) begin
					if (err_cnt < 10)
						$display("unexpected point x=%h y=%h last=%b", point_x, point_y,
							last);
					err_cnt++;
				end else begin
					want = pts_q.pop_front();
					if (want.x !== point_x || want.y !== point_y || want.last !== last) begin
						if (err_cnt < 10)
							$display("point mismatch: expected x=%h y=%h last=%b, got x=%h y=%h last=%b",
								want.x, want.y, want.last, point_x, point_y, last);
						err_cnt++;
					end
				end
			end
			if (cmd_valid && cmd_ready) flatten_curve();
			errors <= err_cnt;
			pending <= pts_q.size();
		end
	end

endmodule

>>> bench/path_curve_flattener_test.sv
// ----------------------------------------------------------------------------
// path_curve_flattener_test
// Drives curve commands and segment count settings into the flattener under
// varying backpressure; the checker beside the block scores every point.
// ----------------------------------------------------------------------------
module path_curve_flattener_test import pcf_pkg::*;;

	localparam logic [2:0] OP_OTHER   = 3'd4;
	localparam logic [31:0] Q_MAX     = 32'h7FFF_FFFF;
	localparam logic [31:0] Q_MIN     = 32'h8000_0000;
	localparam int         STALL_LIMIT = 40000;

	logic        clk, arst_n;
	logic        psel, penable, pwrite, pready;
	logic [2:0]  paddr;
	logic [31:0] pwdata, prdata;
	logic        cmd_valid, cmd_ready;
	logic [2:0]  op;
	logic        relative;
	logic signed [31:0] start_x, start_y, ctrl_a_x, ctrl_a_y;
	logic signed [31:0] ctrl_b_x, ctrl_b_y, end_x, end_y;
	logic        point_valid;
	logic        point_ready = 1'b0;
	logic signed [31:0] point_x, point_y;
	logic        last;
	int          errors, pending;
	int          send_idle_pct, recv_stall_pct;
	int          cur_segs;
	int          quiet_cycles = 0;

	path_curve_flattener uut (.*);

	pcf_checker u_checker (.*);

	always begin
		clk = 1'b1; #4;
		clk = 1'b0; #4;
	end

	always @(posedge clk)
		point_ready <= ($urandom_range(99) >= recv_stall_pct);

	// watchdog on cycles with no transfer on any port
	always @(posedge clk) begin
		if ((cmd_valid && cmd_ready) || (point_valid && point_ready) || (psel && penable))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	task automatic send_curve(input logic [2:0] o, input logic r,
			input logic [31:0] sx, sy, ax, ay, bx, by, ex, ey);
		while ($urandom_range(99) < send_idle_pct) begin
			cmd_valid <= 1'b0;
			@(posedge clk);
		end
		cmd_valid <= 1'b1;
		op <= o; relative <= r;
		start_x <= sx;  start_y <= sy;
		ctrl_a_x <= ax; ctrl_a_y <= ay;
		ctrl_b_x <= bx; ctrl_b_y <= by;
		end_x <= ex;    end_y <= ey;
		do @(posedge clk); while (!cmd_ready);
	endtask

	// drop valid, let every point arrive, then let a pointless curve finish
	task automatic drain();
		cmd_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (100 * cur_segs + 400) @(posedge clk);
	endtask

	task automatic write_reg(input logic [2:0] addr, input logic [31:0] data);
		psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
		paddr <= addr; pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
		if (addr == 3'd0) begin
			cur_segs = data[6:0];
			if (cur_segs < 1) cur_segs = 1;
			if (cur_segs > 64) cur_segs = 64;
		end
	endtask

	function automatic logic [31:0] pick_coord();
		int sel;
		sel = $urandom_range(99);
		if (sel < 75) return $urandom_range(32'h0020_0000) - 32'h0010_0000;
		if (sel < 88) return $urandom;
		if (sel < 94) return Q_MAX - $urandom_range(3);
		return Q_MIN + $urandom_range(3);
	endfunction

	task automatic send_random();
		logic [2:0] o;
		int sel;
		sel = $urandom_range(99);
		o = (sel < 90) ? 3'($urandom_range(3)) : 3'($urandom_range(7, 4));
		send_curve(o, 1'($urandom_range(1)), pick_coord(), pick_coord(), pick_coord(),
			pick_coord(), pick_coord(), pick_coord(), pick_coord(), pick_coord());
	endtask

	initial begin
		int segs_plan[10];
		int chunk;
		segs_plan = '{3, 0, 8, 127, 1, 5, 64, 2, 100, 12};
		arst_n = 1'b0;
		psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
		cmd_valid = 1'b0; op = OP_CUBIC; relative = 1'b0;
		start_x = '0; start_y = '0; ctrl_a_x = '0; ctrl_a_y = '0;
		ctrl_b_x = '0; ctrl_b_y = '0; end_x = '0; end_y = '0;
		send_idle_pct = 7; recv_stall_pct = 49;
		cur_segs = 16;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed commands at the reset segment count
		send_curve(OP_CUBIC, 0, 0, 0, 32'h0001_0000, 32'h0002_0000,
			32'h0003_0000, 32'hFFFF_0000, 32'h0004_0000, 0);
		send_curve(OP_SMOOTH_CUBIC, 0, 32'h0004_0000, 0, 0, 0,
			32'h0005_0000, 32'h0001_0000, 32'h0006_0000, 32'h0002_0000);
		send_curve(OP_CUBIC, 0, 0, 0, 0, 0, Q_MIN, Q_MIN, 32'h0001_0000, 0);
		// reflection past the top of the range
		send_curve(OP_SMOOTH_CUBIC, 0, Q_MAX, Q_MAX, 0, 0, 0, 0, 0, 0);
		send_curve(OP_QUAD, 0, 0, 0, 32'h0003_0000, 32'h0003_0000,
			0, 0, 32'h0006_0000, 0);
		send_curve(OP_SMOOTH_QUAD, 0, 32'h0006_0000, 0, 0, 0, 0, 0,
			32'h000C_0000, 32'h0001_0000);
		send_curve(OP_QUAD, 0, 0, 0, Q_MAX, Q_MAX, 0, 0, 0, 0);
		send_curve(OP_SMOOTH_QUAD, 0, Q_MIN, Q_MIN, 0, 0, 0, 0, 32'h0001_0000, 0);
		// smooth forms with no same-family predecessor
		send_curve(OP_SMOOTH_CUBIC, 1, 32'h0000_8000, 32'h0000_4000, 0, 0,
			32'h0002_0000, 32'h0002_0000, 32'h0003_0000, 32'hFFFE_0000);
		send_curve(OP_OTHER, 0, $urandom, $urandom, 0, 0, 0, 0, 0, 0);
		send_curve(OP_SMOOTH_QUAD, 0, 0, 0, 0, 0, 0, 0, 32'h0002_0000, 32'h0002_0000);
		send_curve(3'd5, 1, Q_MAX, Q_MIN, Q_MAX, Q_MIN, Q_MAX, Q_MIN, Q_MAX, Q_MIN);
		send_curve(3'd6, 0, 0, 0, 0, 0, 0, 0, 0, 0);
		send_curve(3'd7, 1, '1, '1, '1, '1, '1, '1, '1, '1);
		send_curve(OP_SMOOTH_CUBIC, 0, 0, 0, 0, 0, 32'h0001_0000, 0, 32'h0002_0000, 0);
		// relative offsets that clip at both ends
		send_curve(OP_CUBIC, 1, Q_MAX, Q_MIN, Q_MAX, Q_MIN, Q_MAX, Q_MIN, Q_MAX, Q_MIN);
		send_curve(OP_QUAD, 1, Q_MIN, Q_MAX, Q_MIN, Q_MAX, Q_MIN, Q_MAX, Q_MIN, Q_MAX);
		// degenerate: every point equals the start
		send_curve(OP_CUBIC, 0, 32'h1234_5678, 32'h1234_5678, 32'h1234_5678,
			32'h1234_5678, 32'h1234_5678, 32'h1234_5678, 32'h1234_5678, 32'h1234_5678);
		send_curve(OP_QUAD, 1, 32'h0000_0010, 0, 0, 0, 0, 0, 0, 0);
		send_curve(OP_CUBIC, 0, Q_MIN, Q_MAX, Q_MAX, Q_MIN, Q_MIN, Q_MAX, Q_MAX, Q_MIN);
		send_curve(OP_QUAD, 1, '1, '1, '1, '1, '1, '1, '1, '1);
		send_curve(OP_CUBIC, 1, 0, 0, 1, 1, 2, 2, 3, 3);

		drain();
		write_reg(3'd4, $urandom);
		for (chunk = 0; chunk < 10; chunk++) begin
			if (chunk == 4) begin
				send_idle_pct = 49; recv_stall_pct = 7;
			end else if (chunk == 7) begin
				send_idle_pct = 0; recv_stall_pct = 0;
			end
			drain();
			write_reg(3'd0, {$urandom} & 32'hFFFF_FF80 | segs_plan[chunk]);
			repeat ((cur_segs > 16) ? 6 : 28) send_random();
		end
		drain();

		if (errors == 0 && pending == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
